FILE: hdl/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types and widths of the glyph cache lookup: tag entry layout and
// result word.
// ----------------------------------------------------------------------------
package gcl_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned SZ_W    = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 7;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [SZ_W-1:0]    size_key;
    logic [CP_W-1:0]    codepoint;
  } entry_t;

  typedef struct packed {
    logic [CP_W-1:0]   evicted_codepoint;
    logic              evicted;
    logic [SLOT_W-1:0] slot_index;
    logic              hit;
    logic              accepted;
  } result_t;

endpackage

FILE: hdl/gcl_tag_ram.sv
// ----------------------------------------------------------------------------
// gcl_tag_ram
// Single tag memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gcl_tag_ram #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  gcl_pkg::entry_t            wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output gcl_pkg::entry_t            rdata_o
);

  gcl_pkg::entry_t mem_q [ENTRIES];
  gcl_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/gcl_scan.sv
// ----------------------------------------------------------------------------
// gcl_scan
// Per-entry tag compare and running oldest-stamp tracker for the scan.
// ----------------------------------------------------------------------------
module gcl_scan #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic                         clk_i,
  input  logic                         valid_i,
  input  logic [$clog2(ENTRIES)-1:0]   idx_i,
  input  gcl_pkg::entry_t              entry_i,
  input  logic [gcl_pkg::CP_W-1:0]     req_cp_i,
  input  logic [gcl_pkg::SZ_W-1:0]     req_sz_i,
  output logic                         match_o,
  output logic [$clog2(ENTRIES)-1:0]   best_idx_o,
  output logic [gcl_pkg::CP_W-1:0]     best_cp_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [gcl_pkg::STAMP_W-1:0] best_stamp_q;
  logic [IW-1:0]               best_idx_q;
  logic [gcl_pkg::CP_W-1:0]    best_cp_q;
  logic                        take;

  assign match_o = valid_i && (entry_i.codepoint == req_cp_i) && (entry_i.size_key == req_sz_i);
  assign take    = valid_i && ((idx_i == '0) || (entry_i.stamp < best_stamp_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_stamp_q <= entry_i.stamp;
      best_idx_q   <= idx_i;
      best_cp_q    <= entry_i.codepoint;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_cp_o  = best_cp_q;

endmodule

FILE: hdl/glyph_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// glyph_cache_lru_lookup
// Fully associative glyph tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request on the slave stream carries a codepoint and a size key. The block
// scans the filled entries of one tag memory, one entry per cycle, for an
// exact match while it tracks the entry with the oldest use stamp. A hit
// refreshes the stamp; a miss fills the next free entry or, once all ENTRIES
// are filled, replaces the oldest one. One result leaves on the master stream
// per request.
// A request with a zero size key, or one to an empty store, skips the scan
// and goes straight to the result. A new request is taken when the previous
// one is done, so requests do not overlap; the scan is bound by the single
// read port of the tag memory.
// Reset empties the store (fill count and use counter cleared); the tag
// memory itself is not cleared. A stalled master side holds the result in
// the output register; the next request is still taken and scanned, and it
// waits before the write-back until the output register frees.
// ----------------------------------------------------------------------------
module glyph_cache_lru_lookup #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // codepoint[20:0], size_key[36:21], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // accepted, hit, slot_index[8:2], evicted,
                                     // evicted_codepoint[30:10], zero
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [gcl_pkg::CP_W-1:0]    req_cp_q, req_cp_d;
  logic [gcl_pkg::SZ_W-1:0]    req_sz_q, req_sz_d;
  logic [CW-1:0]               issue_q, issue_d;
  logic                        rvalid_q, rvalid_d;
  logic [IW-1:0]               ridx_q, ridx_d;
  logic                        hit_q, hit_d;
  logic [IW-1:0]               hit_idx_q, hit_idx_d;
  logic [CW-1:0]               fill_q, fill_d;
  logic [gcl_pkg::STAMP_W-1:0] counter_q, counter_d;
  logic                        out_valid_q, out_valid_d;
  gcl_pkg::result_t            out_q, out_d;

  logic                        rd_en;
  logic                        wr_en;
  logic [IW-1:0]               slot;
  gcl_pkg::entry_t             wdata;
  gcl_pkg::entry_t             rdata;
  logic                        match;
  logic [IW-1:0]               best_idx;
  logic [gcl_pkg::CP_W-1:0]    best_cp;
  logic                        full;
  logic                        acc;
  logic                        finish;

  assign s_axis_tready = (state_q == S_IDLE);
  assign full          = (fill_q == CW'(ENTRIES));
  assign acc           = (req_sz_q != '0);
  assign rd_en         = (state_q == S_SCAN) && (issue_q < fill_q);
  assign finish        = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign wr_en         = finish && acc;
  assign slot          = hit_q ? hit_idx_q : (full ? best_idx : fill_q[IW-1:0]);

  always_comb begin
    wdata.codepoint = req_cp_q;
    wdata.size_key  = req_sz_q;
    wdata.stamp     = counter_q + 32'd1;
  end

  gcl_tag_ram #(.ENTRIES(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (rdata)
  );

  gcl_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk_i      (clk_i),
    .valid_i    (rvalid_q && (state_q == S_SCAN)),
    .idx_i      (ridx_q),
    .entry_i    (rdata),
    .req_cp_i   (req_cp_q),
    .req_sz_i   (req_sz_q),
    .match_o    (match),
    .best_idx_o (best_idx),
    .best_cp_o  (best_cp)
  );

  always_comb begin
    state_d     = state_q;
    req_cp_d    = req_cp_q;
    req_sz_d    = req_sz_q;
    issue_d     = issue_q;
    rvalid_d    = 1'b0;
    ridx_d      = issue_q[IW-1:0];
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    fill_d      = fill_q;
    counter_d   = counter_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_cp_d = s_axis_tdata[20:0];
          req_sz_d = s_axis_tdata[36:21];
          issue_d  = '0;
          hit_d    = 1'b0;
          if ((s_axis_tdata[36:21] == '0) || (fill_q == '0)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rvalid_d = rd_en;
        if (rd_en) begin
          issue_d = issue_q + CW'(1);
        end
        if (rvalid_q) begin
          if (match) begin
            hit_d     = 1'b1;
            hit_idx_d = ridx_q;
            state_d   = S_DONE;
          end else if ((CW'(ridx_q) + CW'(1)) == fill_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (finish) begin
          out_valid_d           = 1'b1;
          out_d.accepted        = acc;
          out_d.hit             = acc && hit_q;
          out_d.slot_index      = acc ? gcl_pkg::SLOT_W'(slot) : '0;
          out_d.evicted         = acc && !hit_q && full;
          out_d.evicted_codepoint = (acc && !hit_q && full) ? best_cp : '0;
          if (acc) begin
            counter_d = counter_q + 32'd1;
            if (!hit_q && !full) begin
              fill_d = fill_q + CW'(1);
            end
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rvalid_q    <= 1'b0;
      hit_q       <= 1'b0;
      fill_q      <= '0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rvalid_q    <= rvalid_d;
      hit_q       <= hit_d;
      fill_q      <= fill_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_cp_q  <= req_cp_d;
    req_sz_q  <= req_sz_d;
    issue_q   <= issue_d;
    ridx_q    <= ridx_d;
    hit_idx_q <= hit_idx_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(ENTRIES))
    else $error("fill count beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.evicted) |-> (full && !out_q.hit))
    else $error("eviction reported while store not full or on a hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.accepted) |-> (out_q.slot_index == '0 && !out_q.hit
      && !out_q.evicted && out_q.evicted_codepoint == '0))
    else $error("rejected request carries nonzero result fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (state_q == S_IDLE && counter_q == $past(counter_q) + 32'd1))
    else $error("write-back without use counter advance");

endmodule
